// File: hdl/rms_norm_row_gain_macros.svh
// assertion macros for the rms_norm_row_gain checker
// no dependencies
`ifndef RMS_NORM_ROW_GAIN_MACROS_SVH
`define RMS_NORM_ROW_GAIN_MACROS_SVH
`define RNG_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RNG_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`endif

// File: hdl/rng_pkg.sv
// types and constants for rms_norm_row_gain
// no dependencies
`timescale 1ns / 1ps
package rng_pkg;
  localparam int unsigned MAX_ROW_LEN = 64;
  localparam int unsigned ROWLEN_W = 7;
  localparam int unsigned EPS_W    = 25;
  localparam int unsigned INV_W    = 37;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b1;

  typedef struct packed {
    logic signed [15:0] x_sample;
    logic signed [15:0] gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] y_value;
    logic [5:0]         position;
    logic               last_of_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_FILL, ST_DIV, ST_ROOT, ST_EMIT
  } state_t;

  typedef enum logic {
    RT_DIV, RT_SQRT
  } root_ph_t;
endpackage

// File: hdl/rng_divider.sv
// restoring divider: mean = sum / n, one quotient bit a cycle
// no dependencies
`timescale 1ns / 1ps
module rng_divider #(
  parameter int unsigned SUM_W = 37,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [SUM_W-1:0] quot
);
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DEN_W-1:0], q_r[SUM_W-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// File: hdl/rng_isqrt.sv
// inverse root: largest c with c*c*d <= 2^72, as isqrt(floor(2^72 / d))
// depends on rng_pkg
`timescale 1ns / 1ps
module rng_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [37:0]                den,
  output logic                       done,
  output logic [rng_pkg::INV_W-1:0]  inv
);
  // c*c*d <= 2^72 holds exactly when c*c <= floor(2^72 / d)
  localparam int unsigned NUM_W = 73;
  rng_pkg::root_ph_t ph_r, ph_nxt;
  logic [NUM_W-1:0]          q_r, q_nxt;
  logic [37:0]               rem_r, rem_nxt;
  logic [38:0]               trial;
  logic [NUM_W:0]            sq_r, sq_nxt;
  logic [rng_pkg::INV_W-1:0] root_r, root_nxt;
  logic [38:0]               srem_r, srem_nxt;
  logic [40:0]               s_cur, s_trial;
  logic [6:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt, done_r, done_nxt;
  logic [37:0]               d_r, d_nxt;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    sq_nxt = sq_r;
    root_nxt = root_r;
    srem_nxt = srem_r;
    cnt_nxt = cnt_r;
    ph_nxt = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    d_nxt = d_r;
    trial = {rem_r, q_r[NUM_W-1]};
    s_cur = {srem_r, sq_r[NUM_W:NUM_W-1]};
    s_trial = {2'b00, root_r, 2'b01};
    if (start) begin
      q_nxt = {1'b1, {(NUM_W-1){1'b0}}};
      rem_nxt = '0;
      cnt_nxt = 7'(NUM_W);
      ph_nxt = rng_pkg::RT_DIV;
      busy_nxt = 1'b1;
      d_nxt = den;
    end else if (busy_r) begin
      unique case (ph_r)
        rng_pkg::RT_DIV: begin
          if (trial >= {1'b0, d_r}) begin
            rem_nxt = 38'(trial - {1'b0, d_r});
            q_nxt = {q_r[NUM_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[37:0];
            q_nxt = {q_r[NUM_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == 7'd1) begin
            ph_nxt = rng_pkg::RT_SQRT;
            cnt_nxt = 7'(rng_pkg::INV_W);
            sq_nxt = {1'b0, q_nxt};
            root_nxt = '0;
            srem_nxt = '0;
          end
        end
        rng_pkg::RT_SQRT: begin
          if (s_cur >= s_trial) begin
            srem_nxt = 39'(s_cur - s_trial);
            root_nxt = {root_r[rng_pkg::INV_W-2:0], 1'b1};
          end else begin
            srem_nxt = s_cur[38:0];
            root_nxt = {root_r[rng_pkg::INV_W-2:0], 1'b0};
          end
          sq_nxt = {sq_r[NUM_W-2:0], 2'b00};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == 7'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    sq_r <= sq_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    cnt_r <= cnt_nxt;
    d_r <= d_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r <= rng_pkg::RT_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r <= ph_nxt;
    end
  end

  assign done = done_r;
  assign inv = root_r;
endmodule

// File: hdl/rms_norm_row_gain.sv
// top level of rms_norm_row_gain: element store, control and output datapath
// depends on rng_pkg, rng_divider, rng_isqrt
`timescale 1ns / 1ps
// One item is taken per cycle while a row fills; the item that completes a row
// starts the row pass, during which busy is high: a mean divide, an inverse
// root (73 steps dividing 2^72 by mean plus epsilon, then 37 steps of integer
// square root), then one result per stored element in column order, each result
// showing for one cycle, and the pass ends once the emit pipeline has drained.
// Results cannot be held off.
module rms_norm_row_gain (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  rng_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  output rng_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [rng_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rng_pkg::EPS_W-1:0]            cfg_data
);
  localparam int unsigned AW    = (rng_pkg::MAX_ROW_LEN > 1) ?
                                  $clog2(rng_pkg::MAX_ROW_LEN) : 1;
  localparam int unsigned CW    = $clog2(rng_pkg::MAX_ROW_LEN + 1);
  localparam int unsigned SUM_W = 30 + CW;

  logic [31:0] mem [rng_pkg::MAX_ROW_LEN];
  logic [31:0] rd_r;

  logic [rng_pkg::ROWLEN_W-1:0] row_len_r;
  logic [rng_pkg::EPS_W-1:0]    eps_r;
  rng_pkg::state_t st_r, st_nxt;
  logic [CW-1:0]    fill_r, fill_nxt, len_eff;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic             accept, wr_en;
  logic             div_start, sq_start;
  logic             div_done, sq_done;
  logic [SUM_W-1:0] mean;
  logic [rng_pkg::INV_W-1:0] inv;
  logic [37:0]      den;
  logic [31:0]      sqx;

  // emit pipeline
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic        l1_r, l2_r, l3_r, l4_r;
  logic signed [15:0] g2_r, g3_r;
  logic signed [53:0] xp_r;
  logic signed [30:0] t_r;
  logic signed [46:0] tw_r;
  logic signed [30:0] t_full;
  logic signed [46:0] yv;
  logic signed [15:0] ysat;

  assign accept = start && !busy;
  assign busy = (st_r != rng_pkg::ST_FILL);

  always_comb begin
    if (row_len_r == '0) len_eff = CW'(1);
    else if (32'(row_len_r) > rng_pkg::MAX_ROW_LEN) len_eff = CW'(rng_pkg::MAX_ROW_LEN);
    else len_eff = CW'(row_len_r);
  end

  assign sqx = 32'(in_item.x_sample) * 32'(in_item.x_sample);
  assign wr_en = accept && (32'(fill_r) < rng_pkg::MAX_ROW_LEN);
  assign den = (38'(mean) + 38'(eps_r) == '0) ? 38'd1 : 38'(mean) + 38'(eps_r);

  always_comb begin
    st_nxt = st_r;
    fill_nxt = fill_r;
    sum_nxt = sum_r;
    k_nxt = k_r;
    div_start = 1'b0;
    sq_start = 1'b0;
    unique case (st_r)
      rng_pkg::ST_FILL: begin
        if (accept) begin
          if (wr_en) begin
            fill_nxt = fill_r + 1'b1;
            sum_nxt = sum_r + SUM_W'(sqx);
          end
          if (fill_nxt >= len_eff) begin
            st_nxt = rng_pkg::ST_DIV;
            div_start = 1'b1;
          end
        end
      end
      rng_pkg::ST_DIV: begin
        if (div_done) begin
          st_nxt = rng_pkg::ST_ROOT;
          sq_start = 1'b1;
        end
      end
      rng_pkg::ST_ROOT: begin
        if (sq_done) begin
          st_nxt = rng_pkg::ST_EMIT;
          k_nxt = '0;
        end
      end
      rng_pkg::ST_EMIT: begin
        if (k_r < fill_r) k_nxt = k_r + 1'b1;
        else if (!v1_r && !v2_r && !v3_r && !v4_r) begin
          st_nxt = rng_pkg::ST_FILL;
          fill_nxt = '0;
          sum_nxt = '0;
        end
      end
      default: st_nxt = rng_pkg::ST_FILL;
    endcase
  end

  // divider takes the row totals including the completing item
  rng_divider #(.SUM_W(SUM_W), .DEN_W(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(sum_nxt), .den(fill_nxt), .done(div_done), .quot(mean)
  );

  rng_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .den(den), .done(sq_done), .inv(inv)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[fill_r[AW-1:0]] <= {in_item.x_sample, in_item.gain};
    rd_r <= mem[k_r[AW-1:0]];
  end

  always_comb begin
    t_full = 31'((xp_r + 54'sd8388608) >>> 24);
    yv = (tw_r + 47'sd2048) >>> 12;
    if (yv > 47'sd32767) ysat = 16'sd32767;
    else if (yv < -47'sd32768) ysat = -16'sd32768;
    else ysat = 16'(yv);
  end

  always_ff @(posedge clk) begin
    p1_r <= k_r[AW-1:0];
    l1_r <= (k_r + 1'b1 == fill_r);
    xp_r <= $signed(rd_r[31:16]) * $signed({1'b0, inv});
    g2_r <= $signed(rd_r[15:0]);
    p2_r <= p1_r; l2_r <= l1_r;
    t_r <= t_full; g3_r <= g2_r;
    p3_r <= p2_r; l3_r <= l2_r;
    tw_r <= t_r * g3_r;
    p4_r <= p3_r; l4_r <= l3_r;
    out_item.y_value <= ysat;
    out_item.position <= 6'(p4_r);
    out_item.last_of_row <= l4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rng_pkg::ST_FILL;
      fill_r <= '0;
      sum_r <= '0;
      k_r <= '0;
      row_len_r <= rng_pkg::ROWLEN_W'(64);
      eps_r <= rng_pkg::EPS_W'(16777);
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      sum_r <= sum_nxt;
      k_r <= k_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rng_pkg::REG_ROW_LEN: row_len_r <= cfg_data[rng_pkg::ROWLEN_W-1:0];
          rng_pkg::REG_EPSILON: eps_r <= cfg_data;
          default: ;
        endcase
      end
      v1_r <= (st_r == rng_pkg::ST_EMIT) && (k_r < fill_r);
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      out_valid <= v4_r;
    end
  end
endmodule

// File: hdl/rng_checker.sv
// port-level checker for rms_norm_row_gain, bound to the top level
// depends on rng_pkg and rms_norm_row_gain_macros.svh
`timescale 1ns / 1ps
`include "rms_norm_row_gain_macros.svh"
module rng_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input rng_pkg::out_item_t out_item
);
  `RNG_ASSERT_IMPL(a_no_out_while_filling, clk, rst_n, out_valid |-> busy || $past(busy), "result outside row pass")
  `RNG_ASSERT_NEXT(a_pos_steps, clk, rst_n, out_valid && !out_item.last_of_row, (!out_valid || out_item.position == $past(out_item.position) + 6'd1), "position gap")
  `RNG_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_item.last_of_row, !out_valid, "result after last")
endmodule

bind rms_norm_row_gain rng_checker u_rng_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
